### hw/rtl/sed_pkg.sv
// Types and constants shared by the string escape decoder modules.
// No dependencies.
package sed_pkg;

    localparam logic [7:0] C_QUOTE = 8'h27;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_X     = 8'h78;
    localparam logic [7:0] C_B     = 8'h62;
    localparam logic [7:0] C_F     = 8'h66;
    localparam logic [7:0] C_N     = 8'h6E;
    localparam logic [7:0] C_R     = 8'h72;
    localparam logic [7:0] C_T     = 8'h74;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_HT = 8'h09;

    localparam int HEX_RADIX  = 16;
    localparam int OCT_DIGITS = 3;

    localparam logic [1:0] HEX_FULL_CNT = 2'($clog2(HEX_RADIX) / 2);
    localparam logic [1:0] OCT_LAST_CNT = 2'(OCT_DIGITS - 1);

    typedef enum logic [2:0] {
        SED_PLAIN = 3'd0,
        SED_QUOTE = 3'd1,
        SED_BSL   = 3'd2,
        SED_HEX   = 3'd3,
        SED_OCT   = 3'd4
    } t_sed_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_sed_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
    } t_sed_item;

    // Results of one input item, r0 first; cnt is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] cnt;
        t_sed_item  r0;
        t_sed_item  r1;
    } t_sed_pair;

endpackage

### hw/rtl/sed_decode.sv
// Escape decoding state and per-item result generation.
// Depends on sed_pkg.
module sed_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_consume,
    input  sed_pkg::t_sed_in   i_item,
    output sed_pkg::t_sed_pair o_pair
);
    import sed_pkg::*;

    t_sed_mode  r_mode, n_mode, s_mode;
    logic [7:0] r_val, n_val, s_val;
    logic [1:0] r_cnt, n_cnt, s_cnt;

    logic [7:0] b;
    logic       is_hex, is_oct, is_ctrl;
    logic [3:0] hex_val;
    logic [2:0] oct_val;
    logic [7:0] ctrl_byte, hex_acc, oct_acc;
    logic [1:0] hex_cnt;
    logic       hex_full, oct_full;
    t_sed_mode  plain_mode;
    logic       plain_emits;
    t_sed_pair  pair;

    function automatic t_sed_pair push(t_sed_pair p, logic [7:0] v);
        t_sed_item it;
        it = '{out_byte: v, has_byte: 1'b1, end_of_string: 1'b0};
        if (p.cnt == 2'd0) begin
            p.r0 = it;
        end else begin
            p.r1 = it;
        end
        p.cnt = p.cnt + 2'd1;
        return p;
    endfunction

    assign b = i_item.in_byte;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = b[3:0];
        priority if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            hex_val = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        is_ctrl   = 1'b1;
        ctrl_byte = CTRL_BS;
        priority if (b == C_B) begin
            ctrl_byte = CTRL_BS;
        end else if (b == C_F) begin
            ctrl_byte = CTRL_FF;
        end else if (b == C_N) begin
            ctrl_byte = CTRL_LF;
        end else if (b == C_R) begin
            ctrl_byte = CTRL_CR;
        end else if (b == C_T) begin
            ctrl_byte = CTRL_HT;
        end else begin
            is_ctrl = 1'b0;
        end
    end

    assign is_oct   = (b >= 8'h30) && (b <= 8'h37);
    assign oct_val  = b[2:0];
    assign hex_acc  = {r_val[3:0], hex_val};
    assign oct_acc  = {r_val[4:0], oct_val};
    assign hex_cnt  = r_cnt + 2'd1;
    assign hex_full = hex_cnt >= HEX_FULL_CNT;
    assign oct_full = r_cnt >= OCT_LAST_CNT;

    always_comb begin
        plain_emits = 1'b0;
        priority if (b == C_QUOTE) begin
            plain_mode = SED_QUOTE;
        end else if (b == C_BSL) begin
            plain_mode = SED_BSL;
        end else begin
            plain_mode  = SED_PLAIN;
            plain_emits = 1'b1;
        end
    end

    // Next state
    always_comb begin
        s_mode = SED_PLAIN;
        s_val  = r_val;
        s_cnt  = r_cnt;
        unique case (r_mode)
            SED_QUOTE: s_mode = SED_PLAIN;
            SED_BSL: begin
                if (b == C_X) begin
                    s_mode = SED_HEX;
                    s_val  = 8'd0;
                    s_cnt  = 2'd0;
                end else if (is_oct && !is_ctrl) begin
                    s_mode = SED_OCT;
                    s_val  = {5'd0, oct_val};
                    s_cnt  = 2'd1;
                end
            end
            SED_HEX: begin
                if (is_hex) begin
                    s_val  = hex_acc;
                    s_cnt  = hex_cnt;
                    s_mode = hex_full ? SED_PLAIN : SED_HEX;
                end else begin
                    s_mode = plain_mode;
                end
            end
            SED_OCT: begin
                if (is_oct) begin
                    s_val  = oct_acc;
                    s_mode = oct_full ? SED_PLAIN : SED_OCT;
                    if (!oct_full) begin
                        s_cnt = r_cnt + 2'd1;
                    end
                end else begin
                    s_mode = plain_mode;
                end
            end
            default: s_mode = plain_mode;
        endcase
        if (s_mode != SED_HEX && s_mode != SED_OCT) begin
            s_val = 8'd0;
            s_cnt = 2'd0;
        end
        n_mode = s_mode;
        n_val  = s_val;
        n_cnt  = s_cnt;
        if (i_item.in_last) begin
            n_mode = SED_PLAIN;
            n_val  = 8'd0;
            n_cnt  = 2'd0;
        end
    end

    // Results
    always_comb begin
        pair = '0;
        unique case (r_mode)
            SED_QUOTE: pair = push(pair, b);
            SED_BSL: begin
                if (is_ctrl) begin
                    pair = push(pair, ctrl_byte);
                end else if (b != C_X && !is_oct) begin
                    pair = push(pair, b);
                end
            end
            SED_HEX: begin
                if (is_hex) begin
                    if (hex_full) begin
                        pair = push(pair, hex_acc);
                    end
                end else begin
                    pair = push(pair, r_val);
                    if (plain_emits) begin
                        pair = push(pair, b);
                    end
                end
            end
            SED_OCT: begin
                if (is_oct) begin
                    if (oct_full) begin
                        pair = push(pair, oct_acc);
                    end
                end else begin
                    pair = push(pair, r_val);
                    if (plain_emits) begin
                        pair = push(pair, b);
                    end
                end
            end
            default: begin
                if (plain_emits) begin
                    pair = push(pair, b);
                end
            end
        endcase
        if (i_item.in_last) begin
            if (s_mode == SED_HEX || s_mode == SED_OCT) begin
                pair = push(pair, s_val);
            end
            if (pair.cnt == 2'd0) begin
                pair.cnt = 2'd1;
                pair.r0  = '{out_byte: 8'd0, has_byte: 1'b0, end_of_string: 1'b1};
            end else if (pair.cnt == 2'd1) begin
                pair.r0.end_of_string = 1'b1;
            end else begin
                pair.r1.end_of_string = 1'b1;
            end
        end
    end

    assign o_pair = pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= SED_PLAIN;
            r_val  <= 8'd0;
            r_cnt  <= 2'd0;
        end else if (i_consume) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_cnt  <= n_cnt;
        end
    end

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_consume && i_item.in_last |=> r_mode == SED_PLAIN && r_val == 8'd0 && r_cnt == 2'd0)
        else $error("state not cleared after last byte");

    a_last_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.in_last |-> pair.cnt != 2'd0)
        else $error("last byte gave no result");

endmodule

### hw/rtl/sed_out_buf.sv
// Two-slot result buffer taking up to two items at once, releasing one per cycle while the consumer is ready.
// Depends on sed_pkg.
module sed_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sed_pkg::t_sed_pair i_pair,
    output logic [1:0]         o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output sed_pkg::t_sed_item o_item
);
    import sed_pkg::*;

    logic [1:0] r_cnt, n_cnt, base;
    t_sed_item  r_slot0, r_slot1, n_slot0, n_slot1;
    logic       pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_slot0;
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - {1'b0, pop};
    assign o_free  = 2'd2 - base;

    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = base;
        if (i_push) begin
            n_cnt = base + i_pair.cnt;
            if (base == 2'd0) begin
                n_slot0 = i_pair.r0;
                n_slot1 = i_pair.r1;
            end else if (base == 2'd1) begin
                n_slot1 = i_pair.r0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> i_pair.cnt <= o_free)
        else $error("result buffer overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

endmodule

### hw/rtl/string_escape_decoder_unit.sv
// Top level of the string escape decoder: input register, decoder, result buffer.
// Depends on sed_pkg, sed_decode and sed_out_buf.
//
// Takes one raw byte of a quoted string literal per cycle and gives its decoded bytes,
// with an end-of-string result on the last byte. An item is accepted every cycle while
// the two-slot result buffer has room; an item whose results fit is decoded in the cycle
// after it is accepted, and its results are then registered into the buffer. The output side
// delivers one result per cycle while the receiver is ready, so an item that yields two results
// (an escape ended by a plain byte) can hold the input back until the buffer has room for both.
module string_escape_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sed_pkg::t_sed_in   i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sed_pkg::t_sed_item o_out_item
);
    import sed_pkg::*;

    logic       r_in_valid;
    t_sed_in    r_in_item;
    t_sed_pair  pair;
    logic [1:0] free;
    logic       consume;

    assign consume    = r_in_valid && (pair.cnt <= free);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    sed_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_item    (r_in_item),
        .o_pair    (pair)
    );

    sed_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (consume),
        .i_pair  (pair),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
